// ----- hdl/rwf_pkg.sv -----
`timescale 1ns / 1ps
package rwf_pkg;

	localparam int FP_WIDTH = 56;
	localparam int POLY_W = FP_WIDTH + 1;
	localparam int WS_W = 7;
	localparam int DEG_W = 6;
	localparam int CFG_W = POLY_W;
	localparam int IDX_W = 1;
	localparam int WINDOW_MAX_DEF = 64;

	localparam logic [IDX_W-1:0] REG_POLY = 1'b0;
	localparam logic [IDX_W-1:0] REG_WINDOW = 1'b1;

	localparam logic [POLY_W-1:0] POLY_RESET = 57'd17349423945073011;
	localparam logic [WS_W-1:0] WINDOW_RESET = 7'd48;
	localparam logic [DEG_W-1:0] SHAMT_RESET = DEG_W'(FP_WIDTH - 8);

	typedef logic [FP_WIDTH-1:0] fp_t;
	typedef logic [7:0][FP_WIDTH-1:0] basis_t;

	typedef struct packed {
		logic busy;
		logic [WS_W-1:0] win;
		fp_t mask;
		logic [DEG_W-1:0] shamt;
		basis_t rb;
		basis_t qb;
	} tables_t;

	// multiply by x modulo the polynomial; mask covers the bits below the degree
	function automatic fp_t gf_mulx(fp_t v, fp_t xd, fp_t mask);
		logic top;
		top = |(v & mask & ~(mask >> 1));
		return ((v << 1) & mask) ^ (top ? xd : '0);
	endfunction

	// linear map of a byte through eight basis values
	function automatic fp_t gf_comb(logic [7:0] sel, basis_t b);
		fp_t acc;
		acc = '0;
		for (int k = 0; k < 8; k++) begin
			if (sel[k])
				acc = acc ^ b[k];
		end
		return acc;
	endfunction

endpackage

// ----- hdl/rwf_in_if.sv -----
`timescale 1ns / 1ps
interface rwf_in_if;
	logic valid;
	logic ready;
	logic kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink (input valid, input kind, input data_byte, output ready);
endinterface

// ----- hdl/rwf_out_if.sv -----
`timescale 1ns / 1ps
interface rwf_out_if;
	logic valid;
	logic ready;
	logic [55:0] fingerprint;

	modport source (output valid, output fingerprint, input ready);
	modport sink (input valid, input fingerprint, output ready);
endinterface

// ----- hdl/rwf_table_gen.sv -----
`timescale 1ns / 1ps
module rwf_table_gen
	import rwf_pkg::*;
#(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0] cfg_data,
	output tables_t tab
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_FIND = 3'd1;
	localparam logic [2:0] ST_RBAS = 3'd2;
	localparam logic [2:0] ST_POW  = 3'd3;
	localparam logic [2:0] ST_QBAS = 3'd4;

	logic [2:0] st_q;
	logic [POLY_W-1:0] poly_q;
	logic [POLY_W-1:0] scan_q;
	logic [WS_W-1:0] win_q;
	fp_t mask_q;
	logic [DEG_W-1:0] shamt_q;
	fp_t cur_q;
	logic [2:0] k_q;
	logic [WS_W-1:0] cnt_q;
	basis_t rb_q;
	basis_t qb_q;

	fp_t xd;
	fp_t cur_x;
	logic [7:0] hi;
	logic [WS_W-1:0] win_new;
	logic poly_ok;

	assign xd = poly_q[FP_WIDTH-1:0] & mask_q;
	assign cur_x = gf_mulx(cur_q, xd, mask_q);
	assign hi = 8'(cur_q >> shamt_q);
	assign poly_ok = |cfg_data[POLY_W-1:8];

	always_comb begin
		win_new = cfg_data[WS_W-1:0];
		if (win_new == '0)
			win_new = WS_W'(1);
		if (int'(win_new) > WINDOW_MAX)
			win_new = WS_W'(WINDOW_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_FIND;
			poly_q <= POLY_RESET;
			scan_q <= POLY_RESET;
			win_q <= WINDOW_RESET;
			mask_q <= '1;
			shamt_q <= SHAMT_RESET;
			cur_q <= '0;
			k_q <= '0;
			cnt_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
				end
				// walk down to the leading one of the polynomial
				ST_FIND: begin
					if (scan_q[POLY_W-1]) begin
						st_q <= ST_RBAS;
						cur_q <= xd;
						k_q <= '0;
					end else begin
						scan_q <= scan_q << 1;
						mask_q <= mask_q >> 1;
						shamt_q <= shamt_q - DEG_W'(1);
					end
				end
				ST_RBAS: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd7) begin
						st_q <= ST_POW;
						cur_q <= FP_WIDTH'(1);
						cnt_q <= WS_W'(1);
					end else begin
						cur_q <= cur_x;
					end
				end
				// x^(8(W-1)) mod poly, one byte shift a cycle
				ST_POW: begin
					if (cnt_q >= win_q) begin
						st_q <= ST_QBAS;
						k_q <= '0;
					end else begin
						cur_q <= ((cur_q << 8) & mask_q) ^ gf_comb(hi, rb_q);
						cnt_q <= cnt_q + WS_W'(1);
					end
				end
				ST_QBAS: begin
					k_q <= k_q + 3'd1;
					cur_q <= cur_x;
					if (k_q == 3'd7)
						st_q <= ST_IDLE;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase

			if (cfg_we) begin
				if (cfg_idx == REG_POLY) begin
					if (poly_ok) begin
						poly_q <= cfg_data;
						scan_q <= cfg_data;
						mask_q <= '1;
						shamt_q <= SHAMT_RESET;
						st_q <= ST_FIND;
					end
				end else if (cfg_idx == REG_WINDOW) begin
					win_q <= win_new;
					scan_q <= poly_q;
					mask_q <= '1;
					shamt_q <= SHAMT_RESET;
					st_q <= ST_FIND;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_RBAS)
			rb_q[k_q] <= cur_q;
		if (st_q == ST_QBAS)
			qb_q[k_q] <= cur_q;
	end

	assign tab.busy = (st_q != ST_IDLE);
	assign tab.win = win_q;
	assign tab.mask = mask_q;
	assign tab.shamt = shamt_q;
	assign tab.rb = rb_q;
	assign tab.qb = qb_q;

endmodule

// ----- hdl/rwf_window_mem.sv -----
`timescale 1ns / 1ps
module rwf_window_mem
	import rwf_pkg::*;
#(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF,
	parameter int AW = 6
) (
	input  logic clk,
	input  logic en,
	input  logic [AW-1:0] addr,
	input  logic [7:0] wdata,
	output logic [7:0] rdata
);

	logic [7:0] mem [WINDOW_MAX];
	logic [7:0] rdata_q;

	// read-first: the old byte leaves as the new one goes in
	always_ff @(posedge clk) begin
		if (en) begin
			rdata_q <= mem[addr];
			mem[addr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/rwf_update.sv -----
`timescale 1ns / 1ps
module rwf_update
	import rwf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic clr,
	input  logic [7:0] data_byte,
	input  logic full,
	input  logic [7:0] old_byte,
	input  tables_t tab,
	output logic ready,
	rwf_out_if.source out_ch
);

	logic valid_s1;
	logic [7:0] c_s1;
	logic full_s1;
	fp_t fp_q;
	logic out_valid_q;
	fp_t out_fp_q;

	logic adv;
	logic [7:0] old;
	logic [7:0] hi;
	fp_t rem;
	fp_t nfp;

	assign adv = !out_valid_q || out_ch.ready;
	assign ready = !valid_s1 || adv;
	assign old = full_s1 ? old_byte : 8'd0;
	assign rem = fp_q ^ gf_comb(old, tab.qb);
	assign hi = 8'(rem >> tab.shamt);
	assign nfp = (((rem << 8) & tab.mask) | FP_WIDTH'(c_s1)) ^ gf_comb(hi, tab.rb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fp_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ready)
				valid_s1 <= push;
			if (valid_s1 && adv) begin
				fp_q <= nfp;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			// a clear beat lands after any byte leaving stage 1 on the same edge
			if (clr)
				fp_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			c_s1 <= data_byte;
			full_s1 <= full;
		end
		if (valid_s1 && adv)
			out_fp_q <= nfp;
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.fingerprint = out_fp_q;

endmodule

// ----- hdl/rolling_window_fingerprint.sv -----
`timescale 1ns / 1ps
// Sliding-window Rabin fingerprint over GF(2).
// in_ch carries one beat per byte: kind 0 pushes data_byte into the window,
// kind 1 clears window and fingerprint and yields no output beat.
// out_ch carries the fingerprint of the window after each pushed byte.
// cfg_we/cfg_idx/cfg_data write poly (index 0) or window_size (index 1);
// write only while no beat is in flight. A poly of degree below 8 is ignored.
// An accepted byte waits in stage 1, then its fingerprint is registered in
// the output register. Throughput: one beat per cycle while out_ch.ready is
// high and no tables are being derived; the old byte read and the new byte
// write share one read-first port of the window memory, and the fingerprint
// update is combinational. After reset and after every accepted register
// write the basis tables are derived again: leading-one search, reduction
// basis, x^(8(W-1)), then removal basis, all with in_ch.ready low; the
// window is cleared meanwhile.
// A stalled receiver holds the output register; one more byte sits in
// stage 1, after which in_ch.ready drops until out_ch.ready returns.
module rolling_window_fingerprint
	import rwf_pkg::*;
#(
	parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
	input  logic clk,
	input  logic arst_n,
	rwf_in_if.sink in_ch,
	rwf_out_if.source out_ch,
	input  logic cfg_we,
	input  logic [IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

	tables_t tab;
	logic upd_ready;
	logic acc;
	logic push;
	logic clr;
	logic [AW-1:0] pos_q;
	logic full_q;
	logic [7:0] old_byte;

	assign in_ch.ready = !tab.busy && upd_ready;
	assign acc = in_ch.valid && in_ch.ready;
	assign push = acc && !in_ch.kind;
	assign clr = (acc && in_ch.kind) || tab.busy;

	// full marks that the window has wrapped since the last clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			full_q <= 1'b0;
		end else if (clr) begin
			pos_q <= '0;
			full_q <= 1'b0;
		end else if (push) begin
			if (int'(pos_q) + 1 >= int'(tab.win)) begin
				pos_q <= '0;
				full_q <= 1'b1;
			end else begin
				pos_q <= pos_q + AW'(1);
			end
		end
	end

	rwf_table_gen #(
		.WINDOW_MAX(WINDOW_MAX)
	) u_table_gen (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.tab(tab)
	);

	rwf_window_mem #(
		.WINDOW_MAX(WINDOW_MAX),
		.AW(AW)
	) u_window_mem (
		.clk(clk),
		.en(push),
		.addr(pos_q),
		.wdata(in_ch.data_byte),
		.rdata(old_byte)
	);

	rwf_update u_update (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.clr(clr),
		.data_byte(in_ch.data_byte),
		.full(full_q),
		.old_byte(old_byte),
		.tab(tab),
		.ready(upd_ready),
		.out_ch(out_ch)
	);

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import rwf_pkg::*;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_CLEAR = 1'b1;

	class fp_scoreboard;
		logic [POLY_W-1:0] poly;
		int deg;
		int wsize;
		logic [7:0] win_mem [WINDOW_MAX_DEF];
		int wpos;
		fp_t fp;
		logic [63:0] red_tab [256];
		fp_t rem_tab [256];
		fp_t pending_fps [$];
		int errors;

		function new();
			poly = POLY_RESET;
			wsize = int'(WINDOW_RESET);
			errors = 0;
			rebuild();
		endfunction

		// byte times b modulo the polynomial, b below 2^deg
		function logic [POLY_W-1:0] gf_mul8(logic [7:0] a, logic [POLY_W-1:0] b);
			logic [POLY_W-1:0] s;
			s = '0;
			for (int k = 7; k >= 0; k--) begin
				s = s << 1;
				if (s[deg])
					s ^= poly;
				if (a[k])
					s ^= b;
			end
			return s;
		endfunction

		function void clear_window();
			foreach (win_mem[i])
				win_mem[i] = '0;
			wpos = 0;
			fp = '0;
		endfunction

		function void rebuild();
			logic [POLY_W-1:0] xd;
			logic [63:0] t;
			logic [7:0] hi;
			deg = 0;
			for (int i = 0; i < POLY_W; i++)
				if (poly[i])
					deg = i;
			xd = poly ^ (POLY_W'(1) << deg);
			for (int i = 0; i < 256; i++)
				red_tab[i] = 64'(gf_mul8(8'(i), xd)) ^ (64'(i) << deg);
			// x^(8(W-1)) mod poly
			t = 64'd1;
			for (int i = 1; i < wsize; i++) begin
				hi = 8'(t >> (deg - 8));
				t = (t << 8) ^ red_tab[hi];
			end
			for (int i = 0; i < 256; i++)
				rem_tab[i] = fp_t'(gf_mul8(8'(i), POLY_W'(t)));
			clear_window();
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			logic [WS_W-1:0] w;
			if (idx == REG_POLY) begin
				// degree below eight: write dropped, window kept
				if (data < 256)
					return;
				poly = data;
				rebuild();
			end else begin
				w = data[WS_W-1:0];
				if (w == 0)
					w = WS_W'(1);
				if (int'(w) > WINDOW_MAX_DEF)
					w = WS_W'(WINDOW_MAX_DEF);
				wsize = int'(w);
				rebuild();
			end
		endfunction

		function void note_beat(logic k, logic [7:0] b);
			logic [7:0] old;
			logic [7:0] hi;
			logic [63:0] acc;
			if (k == KIND_CLEAR) begin
				clear_window();
				return;
			end
			if (wpos >= wsize)
				wpos = 0;
			old = win_mem[wpos];
			win_mem[wpos] = b;
			wpos++;
			if (wpos >= wsize)
				wpos = 0;
			fp ^= rem_tab[old];
			hi = 8'(fp >> (deg - 8));
			acc = ({8'd0, fp} << 8) | 64'(b);
			acc ^= red_tab[hi];
			fp = acc[FP_WIDTH-1:0];
			pending_fps.push_back(fp);
		endfunction

		function void check_fp(fp_t got);
			fp_t want;
			if (pending_fps.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected fingerprint %h", got);
				return;
			end
			want = pending_fps.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10)
					$display("fingerprint mismatch: expected %h, got %h", want, got);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0] cfg_data;
	int gap_pct = 0;
	int stall_pct = 0;
	bit in_held = 1'b0;
	fp_scoreboard sb = new();

	rwf_in_if in_ch();
	rwf_out_if out_ch();

	rolling_window_fingerprint uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	task automatic send_beat(input logic k, input logic [7:0] b);
		in_ch.valid <= 1'b1;
		in_held = 1'b1;
		in_ch.kind <= k;
		in_ch.data_byte <= b;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_beat(k, b);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			in_ch.valid <= 1'b0;
			in_held = 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic write_cfg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		if (in_held) begin
			in_ch.valid <= 1'b0;
			in_held = 1'b0;
		end
		while (sb.pending_fps.size() != 0)
			@(posedge clk);
		// a trailing clear beat may still be in the pipe
		repeat (4) @(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		cfg_we <= 1'b0;
	endtask

	// output back-pressure in bursts
	initial begin
		out_ch.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk)
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_fp(out_ch.fingerprint);

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		int mode;
		int d;
		logic [CFG_W-1:0] v;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_POLY;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.kind <= KIND_PUSH;
		in_ch.data_byte <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: byte extremes and clears under the reset setting
		gap_pct = 10;
		stall_pct = 10;
		send_beat(KIND_PUSH, 8'h00);
		send_beat(KIND_PUSH, 8'hff);
		send_beat(KIND_PUSH, 8'h01);
		send_beat(KIND_PUSH, 8'h80);
		send_beat(KIND_PUSH, 8'h55);
		send_beat(KIND_PUSH, 8'haa);
		send_beat(KIND_CLEAR, 8'hff);
		send_beat(KIND_PUSH, 8'h7f);
		send_beat(KIND_PUSH, 8'hfe);
		// poly of too low a degree must leave the window alone
		write_cfg(REG_POLY, CFG_W'(255));
		send_beat(KIND_PUSH, 8'h3c);
		send_beat(KIND_PUSH, 8'hc3);
		// zero window is taken as one
		write_cfg(REG_WINDOW, CFG_W'(0));
		send_beat(KIND_PUSH, 8'hff);
		send_beat(KIND_PUSH, 8'h00);
		send_beat(KIND_PUSH, 8'ha5);
		// oversized window saturates; bare x^8
		write_cfg(REG_WINDOW, CFG_W'(127));
		write_cfg(REG_POLY, CFG_W'(256));
		send_beat(KIND_PUSH, 8'hff);
		send_beat(KIND_PUSH, 8'h01);
		send_beat(KIND_PUSH, 8'h80);
		write_cfg(REG_POLY, '1);
		write_cfg(REG_WINDOW, CFG_W'(1));
		send_beat(KIND_PUSH, 8'hff);
		send_beat(KIND_PUSH, 8'hff);
		send_beat(KIND_CLEAR, 8'h00);
		send_beat(KIND_PUSH, 8'h80);
		write_cfg(REG_POLY, CFG_W'(285));
		write_cfg(REG_WINDOW, CFG_W'(64));
		send_beat(KIND_PUSH, 8'hff);
		send_beat(KIND_PUSH, 8'h00);
		send_beat(KIND_PUSH, 8'h12);
		send_beat(KIND_PUSH, 8'hed);

		for (int ph = 0; ph < 12; ph++) begin
			mode = $urandom_range(0, 3);
			if (mode != 1) begin
				case ($urandom_range(0, 3))
					0: d = 8;
					1: d = FP_WIDTH;
					default: d = $urandom_range(8, FP_WIDTH);
				endcase
				v = CFG_W'({$urandom(), $urandom()});
				v &= (CFG_W'(1) << d) - 1;
				v |= CFG_W'(1) << d;
				write_cfg(REG_POLY, v);
			end
			if (mode != 0) begin
				v = CFG_W'({$urandom(), $urandom()});
				case ($urandom_range(0, 6))
					0: v[WS_W-1:0] = WS_W'(1);
					1: v[WS_W-1:0] = WS_W'(64);
					2: v[WS_W-1:0] = WS_W'(0);
					3: v[WS_W-1:0] = WS_W'($urandom_range(65, 127));
					default: v[WS_W-1:0] = WS_W'($urandom_range(1, 64));
				endcase
				write_cfg(REG_WINDOW, v);
			end
			if (ph >= 10) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				case ($urandom_range(0, 3))
					0: gap_pct = 0;
					1: gap_pct = 5;
					2: gap_pct = 20;
					default: gap_pct = 50;
				endcase
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 5;
					2: stall_pct = 20;
					default: stall_pct = 50;
				endcase
			end
			for (int i = 0; i < 125; i++) begin
				if (mode == 3 && i == 60)
					write_cfg(REG_POLY, CFG_W'($urandom_range(0, 255)));
				send_beat(($urandom_range(0, 39) == 0) ? KIND_CLEAR : KIND_PUSH,
					8'($urandom_range(0, 255)));
			end
		end

		if (in_held) begin
			in_ch.valid <= 1'b0;
			in_held = 1'b0;
		end
		while (sb.pending_fps.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending_fps.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
